// File: rtl/isu_pkg.sv
// Package with shared constants and types of the Ising spin update block.
package isu_pkg;

    localparam int MaxSide   = 512;
    localparam int ResetSide = 300;
    localparam int CoordW    = 9;
    localparam int SideW     = 10;
    localparam int FracW     = 16;
    localparam int CfgAddrW  = 5;

    localparam logic [2:0] RegExchange = 3'd0;
    localparam logic [2:0] RegFixed    = 3'd1;
    localparam logic [2:0] RegSide     = 3'd2;
    localparam logic [2:0] RegThr2     = 3'd3;
    localparam logic [2:0] RegThr4     = 3'd4;
    localparam logic [2:0] RegThr6     = 3'd5;
    localparam logic [2:0] RegThr8     = 3'd6;

    localparam logic CmdWrite  = 1'b0;
    localparam logic CmdUpdate = 1'b1;

    localparam logic [1:0] DirPosX = 2'd0;
    localparam logic [1:0] DirPosY = 2'd1;
    localparam logic [1:0] DirNegX = 2'd2;
    localparam logic [1:0] DirNegY = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [CoordW-1:0] site_x;
        logic [CoordW-1:0] site_y;
        logic [1:0]        direction;
        logic [FracW-1:0]  random_value;
        logic              write_spin;
    } t_in_item;

    typedef struct packed {
        logic accepted;
        logic spin_after;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an accepted transaction
        logic rd_en;      // issue a grid read
        logic [3:0] rd_sel; // which cell to read
        logic wr_site;    // write the site cell
        logic wr_nb;      // write the neighbour cell
        logic clr_en;     // clearing pass write
    } t_cmd;

    typedef struct packed {
        logic       out_of_grid;
        logic       is_write;
        logic       border_fixed;
        logic       exchange;
        logic       nb_refused;
    } t_status;

    // Read select codes.
    localparam logic [3:0] SelSite = 4'd0;
    localparam logic [3:0] SelS0   = 4'd1;
    localparam logic [3:0] SelS1   = 4'd2;
    localparam logic [3:0] SelS2   = 4'd3;
    localparam logic [3:0] SelS3   = 4'd4;
    localparam logic [3:0] SelNb   = 4'd5;
    localparam logic [3:0] SelN0   = 4'd6;
    localparam logic [3:0] SelN1   = 4'd7;
    localparam logic [3:0] SelN2   = 4'd8;
    localparam logic [3:0] SelN3   = 4'd9;

endpackage

// File: rtl/isu_stream_if.sv
// Valid/ready stream interface that carries one transaction payload.
interface isu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/isu_ctrl.sv
// Controller state machine that sequences grid reads, scoring and write-back.
module isu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  isu_pkg::t_status     i_status,
    input  logic                 i_decide,
    input  logic                 i_clr_done,
    output isu_pkg::t_cmd        o_cmd,
    output logic                 o_finish
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHECK, ST_READ, ST_WAIT, ST_DECIDE, ST_WRITE, ST_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_sel;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = i_in_valid && o_in_ready;
        o_cmd.rd_sel  = r_sel;
        o_cmd.rd_en   = (r_state == ST_READ);
        o_cmd.clr_en  = (r_state == ST_CLEAR);
        o_cmd.wr_site = (r_state == ST_WRITE);
        o_cmd.wr_nb   = (r_state == ST_WRITE) && i_status.exchange && !i_status.is_write;
        o_finish      = (r_state == ST_WRITE) || (r_state == ST_CHECK &&
                        (i_status.out_of_grid));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sel       <= isu_pkg::SelSite;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_clr_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_sel <= isu_pkg::SelSite;
                    if (i_status.out_of_grid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if ((r_sel == isu_pkg::SelN3) ||
                        (r_sel == isu_pkg::SelS3 && !i_status.exchange) ||
                        (r_sel == isu_pkg::SelSite && i_status.is_write) ||
                        (r_sel == isu_pkg::SelSite && i_status.border_fixed)) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_sel <= r_sel + 4'd1;
                    end
                end
                ST_WAIT:   r_state <= ST_DECIDE;
                ST_DECIDE: r_state <= ST_WRITE;
                ST_WRITE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> r_out_valid)
        else $error("result not raised after write-back");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !r_out_valid)
        else $error("transaction taken while a result waits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_nb |-> o_cmd.wr_site)
        else $error("neighbour written without site");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("input ready during clearing pass");
    // i_decide, driven by the datapath, may be high only in ST_DECIDE.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_decide |-> (r_state == ST_DECIDE))
        else $error("decision outside its state");
endmodule

// File: rtl/isu_datapath.sv
// Datapath with the spin memory, neighbour addressing, scoring and acceptance test.
module isu_datapath #(
    parameter int MAX_SIDE = isu_pkg::MaxSide
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  isu_pkg::t_in_item          i_item,
    input  isu_pkg::t_cmd              i_cmd,
    input  logic                       i_finish,
    input  logic                       i_exchange_mode,
    input  logic                       i_fixed_boundary,
    input  logic [isu_pkg::SideW-1:0]  i_side_in_use,
    input  logic [isu_pkg::FracW-1:0]  i_thr2,
    input  logic [isu_pkg::FracW-1:0]  i_thr4,
    input  logic [isu_pkg::FracW-1:0]  i_thr6,
    input  logic [isu_pkg::FracW-1:0]  i_thr8,
    output isu_pkg::t_status           o_status,
    output logic                       o_decide,
    output logic                       o_clr_done,
    output isu_pkg::t_out_item         o_result
);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int EW    = CW + 1;
    localparam int CmpW  = ((isu_pkg::SideW > EW) ? isu_pkg::SideW : EW) + 1;
    localparam int Half  = ((isu_pkg::ResetSide < MAX_SIDE) ? isu_pkg::ResetSide
                                                            : MAX_SIDE) / 2;

    logic r_mem [2**AW];
    logic r_rd_data;

    isu_pkg::t_in_item r_item;
    logic [EW-1:0]     r_side;
    logic [CW-1:0]     r_x, r_y, r_nx, r_ny;
    logic              r_exch, r_fixed;
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_done;
    logic              r_rd_pend;
    logic [3:0]        r_rd_tag;
    logic              r_site, r_nb;
    logic [2:0]        r_agree_s, r_agree_n;
    logic              r_oog, r_accept;
    logic              r_out_acc, r_out_spin;

    logic [EW-1:0]   w_side;
    logic [CmpW-1:0] w_side_sat;
    logic [CmpW-1:0] w_sx, w_sy;

    always_comb begin
        w_side_sat = CmpW'(i_side_in_use);
        if (w_side_sat > CmpW'(MAX_SIDE)) begin
            w_side_sat = CmpW'(MAX_SIDE);
        end else if (w_side_sat < CmpW'(3)) begin
            w_side_sat = CmpW'(3);
        end
        w_side = EW'(w_side_sat);
        w_sx = CmpW'(i_item.site_x);
        w_sy = CmpW'(i_item.site_y);
    end

    function automatic logic [CW-1:0] step(input logic [CW-1:0] c, input logic [1:0] d,
                                           input logic [EW-1:0] side);
        logic [EW-1:0] c1;
        c1 = {1'b0, c} + 1'b1;
        unique case (d)
            2'd1:    step = (c1 >= side) ? '0 : c1[CW-1:0];
            2'd2:    step = (c == '0) ? CW'(side - 1'b1) : c - 1'b1;
            default: step = c;
        endcase
    endfunction

    // Direction codes per axis: 1 plus, 2 minus, 0 still.
    function automatic logic [1:0] dx(input logic [1:0] dir);
        unique case (dir)
            isu_pkg::DirPosX: dx = 2'd1;
            isu_pkg::DirNegX: dx = 2'd2;
            default:          dx = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] dy(input logic [1:0] dir);
        unique case (dir)
            isu_pkg::DirPosY: dy = 2'd1;
            isu_pkg::DirNegY: dy = 2'd2;
            default:          dy = 2'd0;
        endcase
    endfunction

    logic [CW-1:0] w_nx, w_ny, w_rx, w_ry, w_bx, w_by;
    logic [1:0]    w_dir;
    logic          w_is_nb;
    always_comb begin
        w_nx = step(r_x, dx(r_item.direction), r_side);
        w_ny = step(r_y, dy(r_item.direction), r_side);
        w_is_nb = (i_cmd.rd_sel >= isu_pkg::SelNb);
        w_bx = w_is_nb ? r_nx : r_x;
        w_by = w_is_nb ? r_ny : r_y;
        w_dir = 2'(i_cmd.rd_sel - (w_is_nb ? isu_pkg::SelN0 : isu_pkg::SelS0));
        if (i_cmd.rd_sel == isu_pkg::SelSite || i_cmd.rd_sel == isu_pkg::SelNb) begin
            w_rx = w_bx;
            w_ry = w_by;
        end else begin
            w_rx = step(w_bx, dx(w_dir), r_side);
            w_ry = step(w_by, dy(w_dir), r_side);
        end
    end

    logic [2:0] w_score_idx;
    logic [3:0] w_score;
    logic [isu_pkg::FracW-1:0] w_thr;
    logic w_pass;
    always_comb begin
        // Neighbour sum from the agreement count: sum = 2*agree - 4.
        if (r_exch) begin
            w_score = 4'(2 * ({1'b0, r_agree_s} + {1'b0, r_agree_n}));
            // total = 2as-4 + 2an-4 + 2 = 2(as+an) - 6
            w_score_idx = 3'd0;
            if (w_score > 4'd6) begin
                w_score_idx = 3'((w_score - 4'd6) >> 1);
            end
        end else begin
            w_score = 4'(2 * r_agree_s);
            w_score_idx = 3'd0;
            if (w_score > 4'd4) begin
                w_score_idx = 3'((w_score - 4'd4) >> 1);
            end
        end
        unique case (w_score_idx)
            3'd1:    w_thr = i_thr2;
            3'd2:    w_thr = i_thr4;
            3'd3:    w_thr = i_thr6;
            3'd4:    w_thr = i_thr8;
            default: w_thr = '0;
        endcase
        w_pass = (w_score_idx == 3'd0) || (r_item.random_value < w_thr);
    end

    assign o_decide = 1'b0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= (r_clr_addr[CW-1:0] < CW'(Half));
        end else if (i_cmd.wr_site && r_accept) begin
            r_mem[{r_y, r_x}] <= r_item.cmd ? (r_exch ? r_nb : !r_site) : r_item.write_spin;
            if (i_cmd.wr_nb) begin
                r_mem[{r_ny, r_nx}] <= r_site;
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[{w_ry, w_rx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_rd_pend  <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_done <= 1'b1;
                end
            end
            r_rd_pend <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_side  <= w_side;
            r_exch  <= i_exchange_mode;
            r_fixed <= i_fixed_boundary;
            r_oog   <= (w_sx >= w_side_sat) || (w_sy >= w_side_sat);
            r_x     <= CW'(i_item.site_x);
            r_y     <= CW'(i_item.site_y);
            r_agree_s <= '0;
            r_agree_n <= '0;
        end
        r_nx <= w_nx;
        r_ny <= w_ny;
        if (i_cmd.rd_en) begin
            r_rd_tag <= i_cmd.rd_sel;
        end
        if (r_rd_pend) begin
            if (r_rd_tag == isu_pkg::SelSite) begin
                r_site <= r_rd_data;
            end else if (r_rd_tag == isu_pkg::SelNb) begin
                r_nb <= r_rd_data;
            end else if (r_rd_tag < isu_pkg::SelNb) begin
                r_agree_s <= r_agree_s + 3'(r_rd_data == r_site);
            end else begin
                r_agree_n <= r_agree_n + 3'(r_rd_data == r_nb);
            end
        end
        if (!r_item.cmd) begin
            r_accept <= (r_site != r_item.write_spin);
        end else if (o_status.border_fixed) begin
            r_accept <= 1'b0;
        end else if (r_exch) begin
            r_accept <= !o_status.nb_refused && (r_site != r_nb) && w_pass;
        end else begin
            r_accept <= w_pass;
        end
        if (i_finish) begin
            r_out_acc  <= r_oog ? 1'b0 : r_accept;
            r_out_spin <= r_oog ? 1'b0 :
                          (r_accept ? (r_item.cmd ? (r_exch ? r_nb : !r_site)
                                                  : r_item.write_spin) : r_site);
        end
    end

    always_comb begin
        o_status.out_of_grid  = r_oog;
        o_status.is_write     = (r_item.cmd == isu_pkg::CmdWrite);
        o_status.exchange     = r_exch;
        o_status.border_fixed = r_fixed && (r_x == '0 || r_y == '0 ||
                                EW'(r_x) == r_side - 1'b1 || EW'(r_y) == r_side - 1'b1);
        o_status.nb_refused   = r_fixed && (r_nx == '0 || r_ny == '0 ||
                                EW'(r_nx) == r_side - 1'b1 || EW'(r_ny) == r_side - 1'b1);
        o_result.accepted     = r_out_acc;
        o_result.spin_after   = r_out_spin;
    end

    assign o_clr_done = r_clr_done || (i_cmd.clr_en && r_clr_addr == '1);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(i_cmd.rd_en))
        else $error("read data without a read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !i_cmd.rd_en)
        else $error("read during clearing pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_nb |-> r_exch)
        else $error("neighbour write outside exchange mode");
endmodule

// File: rtl/ising_spin_update.sv
// Top level of the Ising spin update block with configuration registers and streams.
// Cells read per transaction: none for a site off the grid, one for a cell write or a fixed
// border site, 5 for a flip attempt and 10 for an exchange.
// One grid bit is read per cycle; a new transaction is taken only after the result of the
// last one is accepted, in the cycle after that at the earliest.
// After reset a clearing pass writes the start pattern into every cell of the spin memory.
module ising_spin_update #(
    parameter int MAX_SIDE = isu_pkg::MaxSide
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    isu_stream_if.sink                      i_in,
    isu_stream_if.source                    o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [isu_pkg::CfgAddrW-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic                          r_exchange_mode, r_fixed_boundary;
    logic [isu_pkg::SideW-1:0]     r_side_in_use;
    logic [isu_pkg::FracW-1:0]     r_thr2, r_thr4, r_thr6, r_thr8;
    logic [2:0]                    w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exchange_mode  <= 1'b0;
            r_fixed_boundary <= 1'b0;
            r_side_in_use    <= isu_pkg::SideW'(isu_pkg::ResetSide);
            r_thr2           <= 16'd11247;
            r_thr4           <= 16'd1930;
            r_thr6           <= 16'd331;
            r_thr8           <= 16'd57;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                isu_pkg::RegExchange: r_exchange_mode  <= pwdata[0];
                isu_pkg::RegFixed:    r_fixed_boundary <= pwdata[0];
                isu_pkg::RegSide:     r_side_in_use    <= pwdata[9:0];
                isu_pkg::RegThr2:     r_thr2           <= pwdata[15:0];
                isu_pkg::RegThr4:     r_thr4           <= pwdata[15:0];
                isu_pkg::RegThr6:     r_thr6           <= pwdata[15:0];
                isu_pkg::RegThr8:     r_thr8           <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            isu_pkg::RegExchange: prdata = {31'd0, r_exchange_mode};
            isu_pkg::RegFixed:    prdata = {31'd0, r_fixed_boundary};
            isu_pkg::RegSide:     prdata = {22'd0, r_side_in_use};
            isu_pkg::RegThr2:     prdata = {16'd0, r_thr2};
            isu_pkg::RegThr4:     prdata = {16'd0, r_thr4};
            isu_pkg::RegThr6:     prdata = {16'd0, r_thr6};
            isu_pkg::RegThr8:     prdata = {16'd0, r_thr8};
            default:              prdata = '0;
        endcase
    end

    isu_pkg::t_cmd    w_cmd;
    isu_pkg::t_status w_status;
    logic             w_decide, w_clr_done, w_finish;

    isu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .i_decide    (w_decide),
        .i_clr_done  (w_clr_done),
        .o_cmd       (w_cmd),
        .o_finish    (w_finish)
    );

    isu_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (i_in.data),
        .i_cmd            (w_cmd),
        .i_finish         (w_finish),
        .i_exchange_mode  (r_exchange_mode),
        .i_fixed_boundary (r_fixed_boundary),
        .i_side_in_use    (r_side_in_use),
        .i_thr2           (r_thr2),
        .i_thr4           (r_thr4),
        .i_thr6           (r_thr6),
        .i_thr8           (r_thr8),
        .o_status         (w_status),
        .o_decide         (w_decide),
        .o_clr_done       (w_clr_done),
        .o_result         (o_out.data)
    );
endmodule
